// ===== hdl/sbl_pkg.sv =====
// Shared types and constants for the Sobel gradient block.
package sbl_pkg;

  typedef logic [7:0] pixel_t;

  // One window column, top to bottom
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  typedef enum logic [1:0] {
    DIR_0DEG   = 2'd0,
    DIR_45DEG  = 2'd1,
    DIR_90DEG  = 2'd2,
    DIR_135DEG = 2'd3
  } dir_e;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_e;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;
  localparam int unsigned MIN_DIM = 3;

  // tan(22.5 deg) ~ 41/100
  localparam logic [16:0] TAN_NUM = 17'd41;
  localparam logic [16:0] TAN_DEN = 17'd100;

endpackage

// ===== hdl/sbl_stream_if.sv =====
// Valid/ready stream interfaces for pixel words and result words.
interface sbl_pix_if
  import sbl_pkg::*;
  ();
  logic   valid;
  logic   ready;
  logic   kind;
  pixel_t pixel;

  modport source (output valid, output kind, output pixel, input ready);
  modport sink   (input valid, input kind, input pixel, output ready);
endinterface

interface sbl_res_if
  import sbl_pkg::*;
  ();
  logic       valid;
  logic       ready;
  logic [7:0] magnitude;
  logic [1:0] direction;
  logic       frame_last;

  modport source (output valid, output magnitude, output direction, output frame_last,
                  input ready);
  modport sink   (input valid, input magnitude, input direction, input frame_last,
                  output ready);
endinterface

// ===== hdl/sbl_line_mem.sv =====
// One line store: single write port, registered read port.
module sbl_line_mem
  import sbl_pkg::*;
  #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
  ) (
    input  logic          clk_i,
    input  logic          rd_en_i,
    input  logic [AW-1:0] rd_addr_i,
    output pixel_t        rd_data_o,
    input  logic          wr_en_i,
    input  logic [AW-1:0] wr_addr_i,
    input  pixel_t        wr_data_i
  );

  pixel_t mem [DEPTH];
  pixel_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/sbl_grad.sv =====
// Sobel kernels, magnitude saturation and direction sector for one window.
module sbl_grad
  import sbl_pkg::*;
  (
    input  column_t    left_i,
    input  column_t    centre_i,
    input  column_t    right_i,
    output logic [7:0] magnitude_o,
    output dir_e       direction_o
  );

  logic [9:0]  sum_right, sum_left, sum_bot, sum_top;
  logic [10:0] gx, gy, gx_abs, gy_abs;
  logic [9:0]  ax, ay;
  logic [10:0] mag_sum;
  logic [16:0] ax_den, ay_den, ax_num, ay_num;

  always_comb begin
    // 1-2-1 weighted sums, each at most 1020
    sum_right = {2'b0, right_i.top} + {1'b0, right_i.mid, 1'b0} + {2'b0, right_i.bot};
    sum_left  = {2'b0, left_i.top} + {1'b0, left_i.mid, 1'b0} + {2'b0, left_i.bot};
    sum_bot   = {2'b0, left_i.bot} + {1'b0, centre_i.bot, 1'b0} + {2'b0, right_i.bot};
    sum_top   = {2'b0, left_i.top} + {1'b0, centre_i.top, 1'b0} + {2'b0, right_i.top};

    gx = {1'b0, sum_right} - {1'b0, sum_left};
    gy = {1'b0, sum_bot} - {1'b0, sum_top};
    gx_abs = gx[10] ? (~gx + 11'd1) : gx;
    gy_abs = gy[10] ? (~gy + 11'd1) : gy;
    ax = gx_abs[9:0];
    ay = gy_abs[9:0];

    mag_sum = {1'b0, ax} + {1'b0, ay};
    magnitude_o = (mag_sum > 11'd255) ? 8'hFF : mag_sum[7:0];

    ax_den = 17'(ax) * TAN_DEN;
    ay_den = 17'(ay) * TAN_DEN;
    ax_num = 17'(ax) * TAN_NUM;
    ay_num = 17'(ay) * TAN_NUM;

    priority if (ay_den <= ax_num) begin
      direction_o = DIR_0DEG;
    end else if (ax_den <= ay_num) begin
      direction_o = DIR_90DEG;
    end else if (gx[10] == gy[10]) begin
      direction_o = DIR_45DEG;
    end else begin
      direction_o = DIR_135DEG;
    end
  end

endmodule

// ===== hdl/sobel_gradient_direction.sv =====
// Streaming 3x3 Sobel gradient magnitude and direction, top level.
//
// pix_i carries gray pixels in raster order (kind = pixel) followed by
// frame_width + 1 flush words (kind = flush) that pad below the frame.
// res_o carries one result word per centre pixel: magnitude |gx|+|gy|
// saturated to 255, direction sector 0/45/90/135 deg, and frame_last on the
// frame's final result. Pixels outside the frame count as zero.
// Results lag the pixels by frame_width + 1 words; the first row gives none.
// Throughput: one word per cycle while res_o does not stall. An accepted word
// passes the registered line store read into the read stage, then the window
// update and kernel into the output register.
// cfg_we_i writes frame_width (index 0) or frame_height (index 1); the user must
// write only while the block is idle (not enforced); each restarts the frame.
// Reset sets 640 x 480, clears the counters and window; the line stores are
// not cleared and are never read before being rewritten.
// When res_o stalls, one word waits in the output register and one more in
// the read stage; pix_i.ready drops only when both are full.
module sobel_gradient_direction
  import sbl_pkg::*;
  #(
    parameter int unsigned MAX_WIDTH = 1024
  ) (
    input  logic                  clk_i,
    input  logic                  rst_ni,
    input  logic                  cfg_we_i,
    input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
    input  logic [CFG_DATA_W-1:0] cfg_data_i,
    sbl_pix_if.sink               pix_i,
    sbl_res_if.source             res_o
  );

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW = (CW + 1 > 11) ? CW + 1 : 11;
  localparam int unsigned RW = 13;

  // configuration
  logic [10:0] frame_width_q;
  logic [11:0] frame_height_q;
  logic        cfg_hit;
  logic [WW-1:0] w_ext, w_use;
  logic [11:0] h_use;
  logic [RW-1:0] h_ext, h_plus1;

  assign cfg_hit = cfg_we_i &&
                   (cfg_idx_i == REG_FRAME_WIDTH || cfg_idx_i == REG_FRAME_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_FRAME_WIDTH) begin
        frame_width_q <= cfg_data_i[10:0];
      end
      if (cfg_idx_i == REG_FRAME_HEIGHT) begin
        frame_height_q <= cfg_data_i[11:0];
      end
    end
  end

  always_comb begin
    w_ext = WW'(frame_width_q);
    if (w_ext < WW'(MIN_DIM)) begin
      w_use = WW'(MIN_DIM);
    end else if (w_ext > WW'(MAX_WIDTH)) begin
      w_use = WW'(MAX_WIDTH);
    end else begin
      w_use = w_ext;
    end
    h_use   = (frame_height_q < 12'(MIN_DIM)) ? 12'(MIN_DIM) : frame_height_q;
    h_ext   = {1'b0, h_use};
    h_plus1 = h_ext + RW'(1);
  end

  // handshake and pipeline control
  logic in_fire, s1_fire, out_valid_q, out_valid_d, s1_valid_q, s1_valid_d;

  assign s1_fire     = s1_valid_q && (!out_valid_q || res_o.ready);
  assign pix_i.ready = !s1_valid_q || s1_fire;
  assign in_fire     = pix_i.valid && pix_i.ready;

  // position counters
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW:0]   col_inc;
  logic          col0, restart;
  pixel_t        pix_v;

  always_comb begin
    col0    = (col_q == '0);
    restart = col0 && (row_q >= h_plus1);
    col_inc = {1'b0, col_q} + (CW + 1)'(1);
    pix_v   = (pix_i.kind == KIND_PIXEL && row_q < h_ext) ? pix_i.pixel : '0;
    col_d   = col_q;
    row_d   = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (in_fire) begin
      if (restart) begin
        col_d = '0;
        row_d = '0;
      end else if (WW'(col_inc) >= w_use) begin
        col_d = '0;
        row_d = row_q + RW'(1);
      end else begin
        col_d = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // read stage
  pixel_t        s1_v_q;
  logic [CW-1:0] s1_col_q;
  logic          s1_top_en_q, s1_mid_en_q, s1_col0_q, s1_emit_q, s1_last_q;

  assign s1_valid_d = in_fire || (s1_valid_q && !s1_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_v_q      <= pix_v;
      s1_col_q    <= col_q;
      s1_top_en_q <= (row_q >= RW'(2));
      s1_mid_en_q <= (row_q >= RW'(1));
      s1_col0_q   <= col0;
      s1_emit_q   <= col0 ? (row_q >= RW'(2)) : (row_q >= RW'(1));
      s1_last_q   <= col0 && (row_q == h_plus1);
    end
  end

  pixel_t upper_rd, lower_rd, top_px, mid_px;

  assign top_px = s1_top_en_q ? upper_rd : '0;
  assign mid_px = s1_mid_en_q ? lower_rd : '0;

  sbl_line_mem #(.DEPTH(MAX_WIDTH), .AW(CW)) u_upper (
    .clk_i     (clk_i),
    .rd_en_i   (in_fire),
    .rd_addr_i (col_q),
    .rd_data_o (upper_rd),
    .wr_en_i   (s1_fire),
    .wr_addr_i (s1_col_q),
    .wr_data_i (mid_px)
  );

  sbl_line_mem #(.DEPTH(MAX_WIDTH), .AW(CW)) u_lower (
    .clk_i     (clk_i),
    .rd_en_i   (in_fire),
    .rd_addr_i (col_q),
    .rd_data_o (lower_rd),
    .wr_en_i   (s1_fire),
    .wr_addr_i (s1_col_q),
    .wr_data_i (s1_v_q)
  );

  // window: only the two newest columns are kept, the oldest drops out
  column_t win1_q, win2_q, new_col, right_col;
  logic [7:0] mag;
  dir_e       dir;

  assign new_col   = '{top: top_px, mid: mid_px, bot: s1_v_q};
  // first column of a row closes the previous row with zero padding on the right
  assign right_col = s1_col0_q ? '0 : new_col;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win1_q <= '0;
      win2_q <= '0;
    end else if (cfg_hit) begin
      win1_q <= '0;
      win2_q <= '0;
    end else if (s1_fire) begin
      win1_q <= s1_col0_q ? '0 : win2_q;
      win2_q <= new_col;
    end
  end

  sbl_grad u_grad (
    .left_i      (win1_q),
    .centre_i    (win2_q),
    .right_i     (right_col),
    .magnitude_o (mag),
    .direction_o (dir)
  );

  // output register
  logic [7:0] mag_q;
  logic [1:0] dir_q;
  logic       last_q;

  assign out_valid_d = (s1_fire && s1_emit_q) || (out_valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_emit_q) begin
      mag_q  <= mag;
      dir_q  <= dir;
      last_q <= s1_last_q;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.magnitude  = mag_q;
  assign res_o.direction  = dir_q;
  assign res_o.frame_last = last_q;

endmodule

// ===== dv/sobel_gradient_direction_tb.sv =====
// Self-checking testbench for the streaming Sobel magnitude/direction block.
`timescale 1ns / 100ps

package sobel_tb_pkg;
  import sbl_pkg::*;

  localparam int unsigned LINE_MAX = 1024;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [7:0] magnitude;
    dir_e       direction;
    logic       frame_last;
  } gradient_t;

  // Mirrors the line stores, window and raster position; queues the gradient
  // words each accepted pixel word should produce.
  class gradient_board;
    pixel_t      upper_line [LINE_MAX];
    pixel_t      lower_line [LINE_MAX];
    pixel_t      win [3][3];
    int unsigned col;
    int unsigned row;
    logic [10:0] width_reg;
    logic [11:0] height_reg;
    gradient_t   gradients_due [$];
    int unsigned errors;

    function new();
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        lower_line[i] = '0;
      end
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      errors     = 0;
      restart();
    endfunction

    function void restart();
      col = 0;
      row = 0;
      foreach (win[i, j]) win[i][j] = '0;
    endfunction

    function int unsigned width_used();
      if (width_reg < MIN_DIM) return MIN_DIM;
      if (width_reg > LINE_MAX) return LINE_MAX;
      return 32'(width_reg);
    endfunction

    function int unsigned height_used();
      if (height_reg < MIN_DIM) return MIN_DIM;
      return 32'(height_reg);
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_FRAME_WIDTH) begin
        width_reg = data[10:0];
        restart();
      end else if (idx == REG_FRAME_HEIGHT) begin
        height_reg = data;
        restart();
      end
    endfunction

    function void shift_window(pixel_t t, pixel_t m, pixel_t b);
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = t;
      win[1][2] = m;
      win[2][2] = b;
    endfunction

    function void add_gradient(bit last);
      int gx, gy, ax, ay;
      gradient_t g;
      gx = (int'(win[0][2]) + 2 * int'(win[1][2]) + int'(win[2][2]))
         - (int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0]));
      gy = (int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2]))
         - (int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2]));
      ax = (gx < 0) ? -gx : gx;
      ay = (gy < 0) ? -gy : gy;
      g.magnitude = (ax + ay > 255) ? 8'd255 : 8'(ax + ay);
      if (100 * ay <= 41 * ax)
        g.direction = DIR_0DEG;
      else if (100 * ax <= 41 * ay)
        g.direction = DIR_90DEG;
      else
        g.direction = ((gx < 0) == (gy < 0)) ? DIR_45DEG : DIR_135DEG;
      g.frame_last = last;
      gradients_due.push_back(g);
    endfunction

    function void take_word(kind_e k, pixel_t p);
      int unsigned w, h, c;
      pixel_t v, t, m;
      w = width_used();
      h = height_used();
      c = col;
      // pixels during padding count as flush, flush inside the frame as zero
      v = (k == KIND_PIXEL && row < h) ? p : '0;
      t = (row >= 2) ? upper_line[c] : '0;
      m = (row >= 1) ? lower_line[c] : '0;
      upper_line[c] = m;
      lower_line[c] = v;
      if (c == 0) begin
        // row wrap: finish the previous row's last centre against padding
        if (row >= 2) begin
          shift_window('0, '0, '0);
          add_gradient(row == h + 1);
        end
        foreach (win[i, j]) win[i][j] = '0;
        win[0][2] = t;
        win[1][2] = m;
        win[2][2] = v;
      end else begin
        shift_window(t, m, v);
        if (row >= 1) add_gradient(1'b0);
      end
      if (c == 0 && row >= h + 1) begin
        restart();
      end else begin
        c++;
        if (c >= w) begin
          c = 0;
          row++;
        end
        col = c;
      end
    endfunction

    function void match_gradient(logic [7:0] mag, logic [1:0] dir, logic last);
      gradient_t g;
      if (gradients_due.size() == 0) begin
        $display("%0t: result word with none due: mag=%0d dir=%0d last=%0b",
                 $time, mag, dir, last);
        errors++;
        return;
      end
      g = gradients_due.pop_front();
      if (mag !== g.magnitude) begin
        $display("%0t: magnitude expected %0d actual %0d", $time, g.magnitude, mag);
        errors++;
      end
      if (dir !== g.direction) begin
        $display("%0t: direction expected %0d actual %0d", $time, g.direction, dir);
        errors++;
      end
      if (last !== g.frame_last) begin
        $display("%0t: frame_last expected %0b actual %0b", $time, g.frame_last, last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return gradients_due.size();
    endfunction
  endclass

endpackage

module sobel_gradient_direction_tb;
  import sbl_pkg::*;
  import sobel_tb_pkg::*;

  typedef enum int unsigned {
    FILL_NOISE,
    FILL_BINARY,
    FILL_FLAT,
    FILL_GRAIN
  } fill_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  sbl_pix_if pix_if ();
  sbl_res_if res_if ();

  gradient_board board;
  int unsigned   words_sent = 0;
  int unsigned   hold_at    = '1;
  int unsigned   pause_at   = '1;
  int unsigned   calm_from  = 0;
  int unsigned   calm_to    = 0;
  bit            calm       = 1'b0;
  bit            hold_rq    = 1'b0;

  sobel_gradient_direction dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix_if),
    .res_o      (res_if)
  );

  always #5 clk_i = ~clk_i;

  // Handshakes are sampled at the falling edge, where everything driven at
  // the rising edge has settled.
  task automatic send_word(input kind_e k, input pixel_t p);
    bit took;
    calm = (words_sent >= calm_from) && (words_sent < calm_to);
    if (words_sent == pause_at) begin
      pix_if.valid <= 1'b0;
      do @(posedge clk_i); while (board.pending() != 0);
    end
    if (words_sent == hold_at) hold_rq = 1'b1;
    while (!calm && $urandom_range(99) < 23) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.kind  <= k;
    pix_if.pixel <= p;
    do begin
      @(negedge clk_i);
      took = pix_if.ready;
      @(posedge clk_i);
    end while (!took);
    board.take_word(k, p);
    words_sent++;
  endtask

  // Only while idle: drain results, then let the pipeline empty.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    pix_if.valid <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
    repeat (6) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    board.set_register(idx, data);
  endtask

  // stop_after != 0 cuts the phase short after that many words
  task automatic run_phase(input logic [CFG_DATA_W-1:0] wdata,
                           input logic [CFG_DATA_W-1:0] hdata,
                           input int unsigned frames, input int unsigned stop_after);
    int unsigned w, h, total, sent;
    fill_e  fill;
    pixel_t base, p;
    kind_e  k;
    write_reg(REG_FRAME_WIDTH, wdata);
    write_reg(REG_FRAME_HEIGHT, hdata);
    if ($urandom_range(3) == 0)
      write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, CFG_DATA_W'($urandom));
    w = board.width_used();
    h = board.height_used();
    total = h * w + w + 1;
    sent = 0;
    for (int f = 0; f < frames; f++) begin
      fill = fill_e'($urandom_range(3));
      base = pixel_t'($urandom_range(255));
      for (int i = 0; i < total; i++) begin
        if (stop_after != 0 && sent == stop_after) return;
        case (fill)
          FILL_NOISE:  p = pixel_t'($urandom_range(255));
          FILL_BINARY: p = $urandom_range(1) ? 8'hFF : 8'h00;
          FILL_FLAT:   p = base;
          default:     p = base ^ pixel_t'($urandom_range(3));
        endcase
        if (i < h * w)
          k = ($urandom_range(99) < 4) ? KIND_FLUSH : KIND_PIXEL;
        else
          k = ($urandom_range(99) < 4) ? KIND_PIXEL : KIND_FLUSH;
        send_word(k, p);
        sent++;
      end
    end
  endtask

  // result side: random ready, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_rq) begin
        hold_rq   = 1'b0;
        hold_left = 300;
      end
      if (hold_left != 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= calm || ($urandom_range(99) >= 23);
      end
      @(negedge clk_i);
      if (res_if.valid && res_if.ready)
        board.match_gradient(res_if.magnitude, res_if.direction, res_if.frame_last);
    end
  end

  initial begin
    int unsigned rand_start, w, h, cut;
    kind_e  demo_kind [13];
    pixel_t demo_pix [13];
    demo_kind = '{KIND_PIXEL, KIND_PIXEL, KIND_PIXEL,
                  KIND_PIXEL, KIND_FLUSH, KIND_PIXEL,
                  KIND_PIXEL, KIND_PIXEL, KIND_PIXEL,
                  KIND_FLUSH, KIND_FLUSH, KIND_PIXEL, KIND_FLUSH};
    demo_pix  = '{8'd0,   8'd0,   8'd255,
                  8'd0,   8'd9,   8'd255,
                  8'd255, 8'd255, 8'd128,
                  8'd0,   8'd0,   8'd77,  8'd0};
    board = new();
    pix_if.valid <= 1'b0;
    pix_if.kind  <= KIND_PIXEL;
    pix_if.pixel <= '0;
    res_if.ready <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= REG_FRAME_WIDTH;
    cfg_data     <= '0;
    rst_ni       <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // partial frame at reset size, cut off by the write
    repeat (4) send_word(KIND_PIXEL, pixel_t'($urandom_range(255)));
    write_reg(REG_FRAME_WIDTH, 12'd3);
    write_reg(REG_FRAME_HEIGHT, 12'd3);
    // 3x3 with edges, saturation, a flush inside and a pixel in the padding
    foreach (demo_kind[i]) send_word(demo_kind[i], demo_pix[i]);

    // size extremes, clamping, and a width word with the spare top bit set
    run_phase(12'd1024, 12'd3, 1, 40);
    run_phase(12'd3, 12'd4095, 1, 30);
    run_phase(12'd2047, 12'd3, 1, 1030);
    run_phase(12'd0, 12'd0, 1, 0);
    run_phase(12'd2, 12'd1, 2, 0);
    run_phase(12'h803, 12'd4, 1, 0);

    rand_start = words_sent;
    hold_at    = rand_start + 100;
    pause_at   = rand_start + 300;
    calm_from  = rand_start + 450;
    calm_to    = rand_start + 600;
    while (words_sent - rand_start < 700) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 3);
      h = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 3);
      cut = ($urandom_range(6) == 0) ? $urandom_range(w * h, 1) : 0;
      run_phase({1'($urandom_range(1)), 11'(w)}, 12'(h), $urandom_range(3, 1), cut);
    end

    pix_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (board.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
